[rtl/generational_refcount_slot_pool_unit_macros.svh]
// assertion macros shared by the rtl
`ifndef GENERATIONAL_REFCOUNT_SLOT_POOL_UNIT_MACROS_SVH
`define GENERATIONAL_REFCOUNT_SLOT_POOL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define GRSP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GRSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GRSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/grsp_pkg.sv]
package grsp_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int IDX_W      = 6;
	localparam int PTR_W      = 7;
	localparam int GEN_W      = 16;
	localparam int CNT_W      = 16;

	localparam logic [1:0] MODE_ACQUIRE = 2'd0;
	localparam logic [1:0] MODE_RETAIN  = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;
	localparam logic [1:0] MODE_LOOKUP  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_POOL_FULL = 3'd1;
	localparam logic [2:0] ST_RANGE     = 3'd2;
	localparam logic [2:0] ST_STALE     = 3'd3;
	localparam logic [2:0] ST_ZERO      = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;

	localparam logic [PTR_W-1:0] EMPTY_PTR = PTR_W'(SLOT_COUNT);
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	typedef struct packed {
		logic [1:0]       mode;
		logic [IDX_W-1:0] slot_index;
		logic [GEN_W-1:0] generation_tag;
	} req_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [IDX_W-1:0] given_slot;
		logic [GEN_W-1:0] slot_generation;
		logic             freed;
	} rsp_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [GEN_W-1:0] gen;
		logic [PTR_W-1:0] link;
	} slot_entry_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

[rtl/grsp_ctrl.sv]
`include "generational_refcount_slot_pool_unit_macros.svh"

module grsp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output grsp_pkg::cmd_t cmd
);

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       rsp_valid_q;
	logic       rsp_free;

	assign req_ready   = (state_q == S_IDLE);
	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = (state_q == S_EXEC) && rsp_free;
	assign rsp_valid   = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`GRSP_ASSERT(a_capture_to_exec, clk, arst_n, cmd.capture |=> state_q == S_EXEC,
		"capture did not enter exec")
	`GRSP_ASSERT(a_commit_gives_rsp, clk, arst_n, cmd.commit |=> rsp_valid_q,
		"commit did not raise response")
	`GRSP_ASSERT(a_no_double_cmd, clk, arst_n, !(cmd.capture && cmd.commit),
		"capture and commit in one cycle")

endmodule

[rtl/grsp_dp.sv]
`include "generational_refcount_slot_pool_unit_macros.svh"

module grsp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  grsp_pkg::cmd_t      cmd,
	input  grsp_pkg::req_item_t req,
	output grsp_pkg::rsp_item_t rsp
);

	grsp_pkg::slot_entry_t mem_q [grsp_pkg::SLOT_COUNT];
	grsp_pkg::slot_entry_t rd_q;
	grsp_pkg::req_item_t   op_q;
	grsp_pkg::rsp_item_t   rsp_q;
	grsp_pkg::rsp_item_t   res;
	grsp_pkg::slot_entry_t wr_data;
	logic [grsp_pkg::PTR_W-1:0] free_head_q;
	logic [grsp_pkg::PTR_W-1:0] in_use_q;
	logic [grsp_pkg::PTR_W-1:0] free_head_d;
	logic [grsp_pkg::PTR_W-1:0] in_use_d;
	logic [grsp_pkg::IDX_W-1:0] rd_addr;
	logic [grsp_pkg::IDX_W-1:0] wr_addr;
	logic                       wr_en;

	assign rd_addr = (req.mode == grsp_pkg::MODE_ACQUIRE)
		? free_head_q[grsp_pkg::IDX_W-1:0] : req.slot_index;

	always_comb begin
		logic [grsp_pkg::CNT_W-1:0] cnt_dec;
		cnt_dec     = rd_q.count - 1'b1;
		res         = '0;
		wr_en       = 1'b0;
		wr_addr     = op_q.slot_index;
		wr_data     = rd_q;
		free_head_d = free_head_q;
		in_use_d    = in_use_q;
		if (op_q.mode == grsp_pkg::MODE_ACQUIRE) begin
			if (!free_head_q[grsp_pkg::PTR_W-1]) begin
				res.given_slot      = free_head_q[grsp_pkg::IDX_W-1:0];
				res.slot_generation = rd_q.gen;
				wr_en               = 1'b1;
				wr_addr             = free_head_q[grsp_pkg::IDX_W-1:0];
				wr_data.count       = grsp_pkg::CNT_W'(1);
				free_head_d         = rd_q.link;
			end else if (!in_use_q[grsp_pkg::PTR_W-1]) begin
				res.given_slot = in_use_q[grsp_pkg::IDX_W-1:0];
				wr_en          = 1'b1;
				wr_addr        = in_use_q[grsp_pkg::IDX_W-1:0];
				wr_data.count  = grsp_pkg::CNT_W'(1);
				wr_data.gen    = '0;
				wr_data.link   = grsp_pkg::EMPTY_PTR;
				in_use_d       = in_use_q + 1'b1;
			end else begin
				res.status = grsp_pkg::ST_POOL_FULL;
			end
		end else if ({1'b0, op_q.slot_index} >= in_use_q) begin
			res.status = grsp_pkg::ST_RANGE;
		end else if (op_q.mode == grsp_pkg::MODE_LOOKUP) begin
			res.given_slot      = op_q.slot_index;
			res.slot_generation = rd_q.gen;
			if (op_q.generation_tag != rd_q.gen) begin
				res.status = grsp_pkg::ST_STALE;
			end
		end else if (rd_q.count == '0) begin
			res.status          = grsp_pkg::ST_ZERO;
			res.slot_generation = rd_q.gen;
		end else if (op_q.mode == grsp_pkg::MODE_RETAIN) begin
			res.slot_generation = rd_q.gen;
			if (rd_q.count == grsp_pkg::CNT_MAX) begin
				res.status = grsp_pkg::ST_OVERFLOW;
			end else begin
				wr_en         = 1'b1;
				wr_data.count = rd_q.count + 1'b1;
			end
		end else begin
			wr_en         = 1'b1;
			wr_data.count = cnt_dec;
			res.slot_generation = rd_q.gen;
			if (cnt_dec == '0) begin
				wr_data.gen         = rd_q.gen + 1'b1;
				wr_data.link        = free_head_q;
				free_head_d         = {1'b0, op_q.slot_index};
				res.slot_generation = rd_q.gen + 1'b1;
				res.freed           = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.capture) begin
			rd_q <= mem_q[rd_addr];
			op_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= grsp_pkg::EMPTY_PTR;
			in_use_q    <= '0;
		end else if (cmd.commit) begin
			free_head_q <= free_head_d;
			in_use_q    <= in_use_d;
		end
	end

	assign rsp = rsp_q;

	`GRSP_ASSERT(a_in_use_bound, clk, arst_n, in_use_q <= grsp_pkg::EMPTY_PTR,
		"slots in use beyond pool")
	`GRSP_ASSERT(a_head_bound, clk, arst_n, free_head_q <= grsp_pkg::EMPTY_PTR,
		"free head beyond pool")
	`GRSP_ASSERT(a_head_used, clk, arst_n,
		(free_head_q != grsp_pkg::EMPTY_PTR) |-> ({1'b0, free_head_q[grsp_pkg::IDX_W-1:0]} < in_use_q),
		"free head names a never used slot")

endmodule

[rtl/generational_refcount_slot_pool_unit.sv]
// channel | valid     | ready     | payload
// request | req_valid | req_ready | req (mode, slot_index, generation_tag)
// result  | rsp_valid | rsp_ready | rsp (status, given_slot, slot_generation, freed)
//
// each item first reads the slot ram, then updates it and the free head or fill mark as needed
// the slot ram is read and then written, so no new request is taken until the last one is written
// reset clears control, free head and fill mark; the ram itself is never cleared
// a new item is taken while a result waits, but it holds in its update cycle
// until the result register is free
module generational_refcount_slot_pool_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  grsp_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output grsp_pkg::rsp_item_t rsp
);

	grsp_pkg::cmd_t cmd;

	grsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	grsp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	grsp_pkg::req_item_t req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	grsp_pkg::rsp_item_t rsp;

	generational_refcount_slot_pool_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// pool state as seen by the request stream
	logic [grsp_pkg::CNT_W-1:0] cnt_m  [grsp_pkg::SLOT_COUNT];
	logic [grsp_pkg::GEN_W-1:0] gen_m  [grsp_pkg::SLOT_COUNT];
	logic [grsp_pkg::PTR_W-1:0] link_m [grsp_pkg::SLOT_COUNT];
	logic [grsp_pkg::PTR_W-1:0] head_m;
	logic [grsp_pkg::PTR_W-1:0] fill_m;

	grsp_pkg::req_item_t op_q[$];
	grsp_pkg::rsp_item_t op_rsp_q[$];
	grsp_pkg::rsp_item_t rsp_due_q[$];
	grsp_pkg::rsp_item_t held_rsp;

	int   err_cnt = 0;
	int   n_status[6] = '{default: 0};
	int   n_freed = 0;
	int   cyc = 0;
	logic quiet;

	assign quiet = cyc >= 1500 && cyc < 2500;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	function automatic grsp_pkg::rsp_item_t pool_apply(grsp_pkg::req_item_t r);
		grsp_pkg::rsp_item_t        o;
		logic [grsp_pkg::IDX_W-1:0] s;
		o = '0;
		if (r.mode == grsp_pkg::MODE_ACQUIRE) begin
			if (head_m < grsp_pkg::SLOT_COUNT) begin
				s = head_m[grsp_pkg::IDX_W-1:0];
				head_m = link_m[s];
			end else if (fill_m < grsp_pkg::SLOT_COUNT) begin
				s = fill_m[grsp_pkg::IDX_W-1:0];
				fill_m = fill_m + 1'b1;
			end else begin
				o.status = grsp_pkg::ST_POOL_FULL;
				return o;
			end
			cnt_m[s] = grsp_pkg::CNT_W'(1);
			o.status = grsp_pkg::ST_OK;
			o.given_slot = s;
			o.slot_generation = gen_m[s];
			return o;
		end
		if (r.slot_index >= fill_m) begin
			o.status = grsp_pkg::ST_RANGE;
			return o;
		end
		s = r.slot_index;
		o.slot_generation = gen_m[s];
		if (r.mode == grsp_pkg::MODE_LOOKUP) begin
			o.given_slot = s;
			o.status = (r.generation_tag != gen_m[s]) ? grsp_pkg::ST_STALE : grsp_pkg::ST_OK;
			return o;
		end
		if (cnt_m[s] == '0) begin
			o.status = grsp_pkg::ST_ZERO;
			return o;
		end
		if (r.mode == grsp_pkg::MODE_RETAIN) begin
			if (cnt_m[s] == grsp_pkg::CNT_MAX) begin
				o.status = grsp_pkg::ST_OVERFLOW;
			end else begin
				cnt_m[s] = cnt_m[s] + 1'b1;
				o.status = grsp_pkg::ST_OK;
			end
			return o;
		end
		cnt_m[s] = cnt_m[s] - 1'b1;
		o.status = grsp_pkg::ST_OK;
		if (cnt_m[s] == '0) begin
			gen_m[s] = gen_m[s] + 1'b1;
			link_m[s] = head_m;
			head_m = {1'b0, s};
			o.freed = 1'b1;
			o.slot_generation = gen_m[s];
		end
		return o;
	endfunction

	function automatic grsp_pkg::rsp_item_t push_op(logic [1:0] m,
			logic [grsp_pkg::IDX_W-1:0] ix, logic [grsp_pkg::GEN_W-1:0] tg);
		grsp_pkg::req_item_t r;
		grsp_pkg::rsp_item_t p;
		r.mode = m;
		r.slot_index = ix;
		r.generation_tag = tg;
		p = pool_apply(r);
		op_q.insert(op_q.size(), r);
		op_rsp_q.insert(op_rsp_q.size(), p);
		return p;
	endfunction

	function automatic logic [grsp_pkg::IDX_W-1:0] used_slot();
		if (fill_m == '0)
			return grsp_pkg::IDX_W'($urandom_range(grsp_pkg::SLOT_COUNT - 1));
		return grsp_pkg::IDX_W'($urandom_range(fill_m - 1));
	endfunction

	function automatic logic [grsp_pkg::IDX_W-1:0] pick_live();
		logic [grsp_pkg::IDX_W-1:0] s;
		s = used_slot();
		for (int t = 0; t < 16; t++) begin
			if (s < fill_m && cnt_m[s] != '0)
				return s;
			s = used_slot();
		end
		return s;
	endfunction

	function automatic logic [grsp_pkg::GEN_W-1:0] rand_tag();
		return grsp_pkg::GEN_W'($urandom_range(16'hFFFF));
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready)
				rsp_due_q.insert(rsp_due_q.size(), held_rsp);
			if (!req_valid || req_ready) begin
				if (op_q.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
					req <= op_q.pop_front();
					held_rsp = op_rsp_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= quiet || ($urandom_range(99) >= 7);
	end

	// monitor
	always @(posedge clk) begin
		grsp_pkg::rsp_item_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_due_q.size() == 0) begin
				$error("result item with nothing expected: status %0d",
					rsp.status);
				err_cnt++;
			end else begin
				e = rsp_due_q.pop_front();
				if (rsp.status != e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp.status);
					err_cnt++;
				end
				if (rsp.given_slot != e.given_slot) begin
					$error("given_slot: expected %0d, got %0d", e.given_slot,
						rsp.given_slot);
					err_cnt++;
				end
				if (rsp.slot_generation != e.slot_generation) begin
					$error("slot_generation: expected %0h, got %0h", e.slot_generation,
						rsp.slot_generation);
					err_cnt++;
				end
				if (rsp.freed != e.freed) begin
					$error("freed: expected %0d, got %0d", e.freed, rsp.freed);
					err_cnt++;
				end
				if (e.status < 6)
					n_status[e.status]++;
				if (e.freed)
					n_freed++;
			end
		end
	end

	initial begin
		#1_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		grsp_pkg::rsp_item_t        p;
		logic [grsp_pkg::IDX_W-1:0] s;
		logic [grsp_pkg::GEN_W-1:0] tg;
		int                         acq_w;
		int                         rel_w;
		int                         r;
		int                         tot;

		for (int i = 0; i < grsp_pkg::SLOT_COUNT; i++) begin
			cnt_m[i] = '0;
			gen_m[i] = '0;
			link_m[i] = grsp_pkg::EMPTY_PTR;
		end
		head_m = grsp_pkg::EMPTY_PTR;
		fill_m = '0;

		// empty pool, then one slot through its whole life
		void'(push_op(grsp_pkg::MODE_LOOKUP, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_RETAIN, 6'd63, 16'hFFFF));
		void'(push_op(grsp_pkg::MODE_RELEASE, 6'd5, 16'd0));
		void'(push_op(grsp_pkg::MODE_ACQUIRE, 6'd63, 16'hFFFF));
		void'(push_op(grsp_pkg::MODE_LOOKUP, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_LOOKUP, 6'd0, 16'hFFFF));
		void'(push_op(grsp_pkg::MODE_RETAIN, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_RELEASE, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_RELEASE, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_RELEASE, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_RETAIN, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_LOOKUP, 6'd0, 16'd1));
		void'(push_op(grsp_pkg::MODE_LOOKUP, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_ACQUIRE, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_ACQUIRE, 6'd0, 16'd0));
		void'(push_op(grsp_pkg::MODE_LOOKUP, 6'd63, 16'd0));
		void'(push_op(grsp_pkg::MODE_LOOKUP, 6'd1, 16'd0));
		void'(push_op(grsp_pkg::MODE_RELEASE, 6'd1, 16'd0));

		// retain one slot many times
		p = push_op(grsp_pkg::MODE_ACQUIRE, 6'd0, 16'd0);
		s = p.given_slot;
		for (int i = 0; i < 32; i++)
			void'(push_op(grsp_pkg::MODE_RETAIN, s, rand_tag()));

		// cycle slots through the free list
		for (int i = 0; i < 32; i++) begin
			p = push_op(grsp_pkg::MODE_ACQUIRE, used_slot(), rand_tag());
			void'(push_op(grsp_pkg::MODE_RELEASE, p.given_slot, rand_tag()));
		end
		void'(push_op(grsp_pkg::MODE_LOOKUP, p.given_slot, 16'd0));

		// exhaust the pool
		do
			p = push_op(grsp_pkg::MODE_ACQUIRE, used_slot(), rand_tag());
		while (p.status != grsp_pkg::ST_POOL_FULL);
		void'(push_op(grsp_pkg::MODE_ACQUIRE, 6'd63, 16'hFFFF));

		// random traffic, alternating acquire-heavy and release-heavy stretches
		for (int i = 0; i < 1470; i++) begin
			acq_w = ((i / 150) % 2 == 0) ? 10 : 40;
			rel_w = ((i / 150) % 2 == 0) ? 45 : 15;
			if ($urandom_range(99) < 5) begin
				void'(push_op(2'($urandom_range(3)),
					grsp_pkg::IDX_W'($urandom_range(63)), rand_tag()));
			end else begin
				r = $urandom_range(99);
				if (r < acq_w) begin
					void'(push_op(grsp_pkg::MODE_ACQUIRE,
						grsp_pkg::IDX_W'($urandom_range(63)), rand_tag()));
				end else if (r < acq_w + 15) begin
					void'(push_op(grsp_pkg::MODE_RETAIN, pick_live(), rand_tag()));
				end else if (r < acq_w + 15 + rel_w) begin
					void'(push_op(grsp_pkg::MODE_RELEASE, pick_live(), rand_tag()));
				end else begin
					s = $urandom_range(1) ? pick_live() : used_slot();
					tg = gen_m[s];
					case ($urandom_range(3))
						0: tg = rand_tag();
						1: tg = tg ^ (grsp_pkg::GEN_W'(1) << $urandom_range(grsp_pkg::GEN_W - 1));
						default: ;
					endcase
					void'(push_op(grsp_pkg::MODE_LOOKUP, s, tg));
				end
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (op_q.size() > 0 || req_valid || rsp_due_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		tot = n_status[0] + n_status[1] + n_status[2] + n_status[3] + n_status[4]
			+ n_status[5];
		$display("checked %0d results: %0d ok, %0d pool full, %0d out of range, %0d stale",
			tot, n_status[0], n_status[1], n_status[2], n_status[3]);
		$display("  %0d count zero, %0d count overflow, %0d slots freed",
			n_status[4], n_status[5], n_freed);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[generational_refcount_slot_pool_unit.f]
+incdir+rtl
rtl/grsp_pkg.sv
rtl/grsp_ctrl.sv
rtl/grsp_dp.sv
rtl/generational_refcount_slot_pool_unit.sv
dv/tb.sv
